// ===== sv/pps_pkg.sv =====
// Shared types, constants and grading functions for the pulse-spacing grader.
`default_nettype none

package pps_pkg;

    localparam int unsigned CFG_W       = 32;
    localparam int unsigned GAP_W       = 32;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned ARRIVAL_W   = 48;
    localparam int unsigned PIXEL_W     = 5;
    localparam int unsigned OUT_COUNT_W = 32;
    localparam int unsigned GRADE_W     = 3;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [GAP_W-1:0] INITIAL_GAP = 32'd12288;
    localparam logic [GAP_W-1:0] GAP_MAX     = 32'hFFFF_FFFF;

    localparam logic [CFG_W-1:0] RST_LOW_MID   = 32'd446;
    localparam logic [CFG_W-1:0] RST_MID_HI    = 32'd1757;
    localparam logic [CFG_W-1:0] RST_SECONDARY = 32'd1757;
    localparam logic [CFG_W-1:0] RST_ASSUMED   = 32'd12288;

    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_MID   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MID_HI    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECONDARY = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ASSUMED   = 3'd3;

    // pixels that are treated as off-pixel
    localparam logic [PIXEL_W-1:0] PIX_SKIP_A = 5'd2;
    localparam logic [PIXEL_W-1:0] PIX_SKIP_B = 5'd3;

    typedef enum logic [GRADE_W-1:0] {
        GR_H  = 3'd0,
        GR_M  = 3'd1,
        GR_MS = 3'd2,
        GR_L  = 3'd3,
        GR_LS = 3'd4,
        GR_S  = 3'd5
    } t_grade;

    typedef struct packed {
        logic [CFG_W-1:0] low_mid_gap;
        logic [CFG_W-1:0] mid_hi_gap;
        logic [CFG_W-1:0] secondary_gap;
        logic [CFG_W-1:0] assumed_next_gap;
    } t_cfg;

    // which counters an event of a given grade lands in
    typedef struct packed {
        logic hires;
        logic hires_mp;
        logic mid_sec;
        logic low;
    } t_class;

    function automatic t_grade grade_of(input logic [GAP_W-1:0] tb,
                                        input logic [GAP_W-1:0] ta,
                                        input t_cfg cfg);
        logic   low;
        logic   mid;
        logic   sec;
        t_grade g;
        low = (tb < cfg.low_mid_gap) || (ta < cfg.low_mid_gap);
        mid = (tb < cfg.mid_hi_gap) || (ta < cfg.mid_hi_gap);
        sec = tb < cfg.secondary_gap;
        if (low) begin
            g = sec ? GR_LS : GR_L;
        end else if (mid) begin
            g = sec ? GR_MS : GR_M;
        end else begin
            g = sec ? GR_S : GR_H;
        end
        return g;
    endfunction

    function automatic t_class class_of(input logic [GRADE_W-1:0] g);
        t_class c;
        c = '0;
        case (g)
            GR_H: begin
                c.hires    = 1'b1;
                c.hires_mp = 1'b1;
            end
            GR_M:  c.hires_mp = 1'b1;
            GR_MS: c.mid_sec  = 1'b1;
            default: c.low = 1'b1;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/pps_front.sv =====
// Front end: takes an event, decides whether it is graded, trims the time stamp.
`default_nettype none

module pps_front #(
    parameter int PIXEL_COUNT = 32,
    parameter int TIME_BITS   = 48,
    localparam int IW         = $clog2(PIXEL_COUNT)
) (
    input  wire logic                           i_start,
    input  wire logic                           i_busy,
    input  wire logic [pps_pkg::PIXEL_W-1:0]    i_pixel_number,
    input  wire logic                           i_on_pixel,
    input  wire logic [pps_pkg::ARRIVAL_W-1:0]  i_arrival_ticks,
    output logic                                o_push,
    output logic                                o_graded,
    output logic [IW-1:0]                       o_idx,
    output logic [TIME_BITS-1:0]                o_time
);

    assign o_push   = i_start && !i_busy;
    assign o_graded = i_on_pixel
                   && (i_pixel_number != pps_pkg::PIX_SKIP_A)
                   && (i_pixel_number != pps_pkg::PIX_SKIP_B)
                   && (32'(i_pixel_number) < 32'(PIXEL_COUNT));
    assign o_idx    = IW'(i_pixel_number);
    // time runs modulo 2^TIME_BITS
    assign o_time   = TIME_BITS'(i_arrival_ticks);

endmodule

`default_nettype wire

// ===== sv/pps_queue.sv =====
// Short item queue between the front end and the grading engine.
`default_nettype none

module pps_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_not_empty,
    output logic                  o_full
);

    localparam int AW = $clog2(pps_pkg::QUEUE_DEPTH);
    localparam int CW = AW + 1;

    logic [WIDTH-1:0] r_data [pps_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wr_ptr;
    logic [AW-1:0]    n_rd_ptr;

    assign o_data      = r_data[r_rd_ptr];
    assign o_not_empty = (r_count != '0);
    assign o_full      = (r_count == CW'(pps_pkg::QUEUE_DEPTH));

    assign n_wr_ptr = (r_wr_ptr == AW'(pps_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == AW'(pps_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CW'(pps_pkg::QUEUE_DEPTH)))
        else $error("item pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("item popped from an empty queue");

endmodule

`default_nettype wire

// ===== sv/pps_back.sv =====
// Grading engine: per-pixel table read-modify-write, gap, grades and counters.
`default_nettype none

module pps_back #(
    parameter int PIXEL_COUNT = 32,
    parameter int TIME_BITS   = 48,
    parameter int COUNT_BITS  = 32,
    localparam int IW         = $clog2(PIXEL_COUNT)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pps_pkg::t_cfg                     i_cfg,
    input  wire logic                              i_q_valid,
    input  wire logic                              i_q_graded,
    input  wire logic [IW-1:0]                     i_q_idx,
    input  wire logic [TIME_BITS-1:0]              i_q_time,
    output logic                                   o_pop,
    output logic                                   o_valid,
    output logic                                   o_graded,
    output logic [pps_pkg::GRADE_W-1:0]            o_prior_final_grade,
    output logic [pps_pkg::GRADE_W-1:0]            o_tentative_grade,
    output logic [pps_pkg::OUT_COUNT_W-1:0]        o_total_events,
    output logic [pps_pkg::OUT_COUNT_W-1:0]        o_hires_events,
    output logic [pps_pkg::OUT_COUNT_W-1:0]        o_hires_midprimary_events,
    output logic [pps_pkg::OUT_COUNT_W-1:0]        o_mid_secondary_events,
    output logic [pps_pkg::OUT_COUNT_W-1:0]        o_low_events
);

    // difference width: wide enough to see a gap beyond the 32-bit range
    localparam int DW = (TIME_BITS > pps_pkg::GAP_W) ? TIME_BITS : pps_pkg::GAP_W + 1;

    typedef struct packed {
        logic [TIME_BITS-1:0]          last;
        logic [pps_pkg::GAP_W-1:0]     gap;
        logic [pps_pkg::GRADE_W-1:0]   held;
        logic [COUNT_BITS-1:0]         total;
        logic [COUNT_BITS-1:0]         hires;
        logic [COUNT_BITS-1:0]         hires_mp;
        logic [COUNT_BITS-1:0]         mid_sec;
        logic [COUNT_BITS-1:0]         low;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GAP,
        ST_UPD
    } t_state;

    t_state                        r_state;
    t_entry                        r_mem [PIXEL_COUNT];
    t_entry                        r_rd;
    t_entry                        r_base;
    logic [PIXEL_COUNT-1:0]        r_seen;
    logic                          r_seen_rd;
    logic [IW-1:0]                 r_idx;
    logic [TIME_BITS-1:0]          r_time;
    logic [pps_pkg::GAP_W-1:0]     r_gap;

    logic                                r_valid;
    logic                                r_graded;
    logic [pps_pkg::GRADE_W-1:0]         r_prior;
    logic [pps_pkg::GRADE_W-1:0]         r_tent;
    logic [pps_pkg::OUT_COUNT_W-1:0]     r_total;
    logic [pps_pkg::OUT_COUNT_W-1:0]     r_hires;
    logic [pps_pkg::OUT_COUNT_W-1:0]     r_hires_mp;
    logic [pps_pkg::OUT_COUNT_W-1:0]     r_mid_sec;
    logic [pps_pkg::OUT_COUNT_W-1:0]     r_low;

    logic                          start_rd;
    logic                          mem_we;
    t_entry                        base;
    logic [DW-1:0]                 diff;
    logic [pps_pkg::GAP_W-1:0]     gap;
    pps_pkg::t_grade               prior;
    pps_pkg::t_grade               tent;
    pps_pkg::t_class               cls_prior;
    pps_pkg::t_class               cls_tent;
    pps_pkg::t_class               cls_held;
    t_entry                        n_entry;

    // counter plus two possible adds and one possible remove; net -1..+2
    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] cnt,
                                                   input logic add_a,
                                                   input logic add_b,
                                                   input logic sub);
        logic [2:0] d;
        d = 3'(add_a) + 3'(add_b) - 3'(sub);
        return cnt + {{(COUNT_BITS - 3){d[2]}}, d};
    endfunction

    assign o_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign start_rd = o_pop && i_q_graded;
    assign mem_we   = (r_state == ST_UPD);

    // an unseen pixel reads as its reset contents
    always_comb begin
        base = r_rd;
        if (!r_seen_rd) begin
            base.gap      = pps_pkg::INITIAL_GAP;
            base.held     = pps_pkg::GR_H;
            base.total    = '0;
            base.hires    = '0;
            base.hires_mp = '0;
            base.mid_sec  = '0;
            base.low      = '0;
        end
    end

    assign diff = DW'(r_time) - DW'(r_rd.last);

    always_comb begin
        if (!r_seen_rd) begin
            gap = pps_pkg::GAP_MAX;
        end else if (r_time < r_rd.last) begin
            gap = '0;
        end else if (diff > DW'(pps_pkg::GAP_MAX)) begin
            gap = pps_pkg::GAP_MAX;
        end else begin
            gap = diff[pps_pkg::GAP_W-1:0];
        end
    end

    assign prior     = pps_pkg::grade_of(r_base.gap, r_gap, i_cfg);
    assign tent      = pps_pkg::grade_of(r_gap, i_cfg.assumed_next_gap, i_cfg);
    assign cls_tent  = pps_pkg::class_of(tent);
    // final-grade correction only for a pixel that already had an event
    assign cls_prior = r_seen_rd ? pps_pkg::class_of(prior) : '0;
    assign cls_held  = r_seen_rd ? pps_pkg::class_of(r_base.held) : '0;

    always_comb begin
        n_entry.last     = r_time;
        n_entry.gap      = r_gap;
        n_entry.held     = tent;
        n_entry.total    = r_base.total + COUNT_BITS'(1);
        n_entry.hires    = bump(r_base.hires, cls_prior.hires, cls_tent.hires, cls_held.hires);
        n_entry.hires_mp = bump(r_base.hires_mp, cls_prior.hires_mp, cls_tent.hires_mp,
                                cls_held.hires_mp);
        n_entry.mid_sec  = bump(r_base.mid_sec, cls_prior.mid_sec, cls_tent.mid_sec,
                                cls_held.mid_sec);
        n_entry.low      = bump(r_base.low, cls_prior.low, cls_tent.low, cls_held.low);
    end

    // per-pixel table
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= n_entry;
        end
        if (start_rd) begin
            r_rd <= r_mem[i_q_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_seen  <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        if (i_q_graded) begin
                            r_idx     <= i_q_idx;
                            r_time    <= i_q_time;
                            r_seen_rd <= r_seen[i_q_idx];
                            r_state   <= ST_GAP;
                        end else begin
                            r_valid    <= 1'b1;
                            r_graded   <= 1'b0;
                            r_prior    <= '0;
                            r_tent     <= '0;
                            r_total    <= '0;
                            r_hires    <= '0;
                            r_hires_mp <= '0;
                            r_mid_sec  <= '0;
                            r_low      <= '0;
                        end
                    end
                end
                ST_GAP: begin
                    r_gap   <= gap;
                    r_base  <= base;
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    r_valid       <= 1'b1;
                    r_graded      <= 1'b1;
                    r_prior       <= prior;
                    r_tent        <= tent;
                    r_total       <= pps_pkg::OUT_COUNT_W'(n_entry.total);
                    r_hires       <= pps_pkg::OUT_COUNT_W'(n_entry.hires);
                    r_hires_mp    <= pps_pkg::OUT_COUNT_W'(n_entry.hires_mp);
                    r_mid_sec     <= pps_pkg::OUT_COUNT_W'(n_entry.mid_sec);
                    r_low         <= pps_pkg::OUT_COUNT_W'(n_entry.low);
                    r_seen[r_idx] <= 1'b1;
                    r_state       <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid                   = r_valid;
    assign o_graded                  = r_graded;
    assign o_prior_final_grade       = r_prior;
    assign o_tentative_grade         = r_tent;
    assign o_total_events            = r_total;
    assign o_hires_events            = r_hires;
    assign o_hires_midprimary_events = r_hires_mp;
    assign o_mid_secondary_events    = r_mid_sec;
    assign o_low_events              = r_low;

    a_graded_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_graded) |-> $past(r_state == ST_UPD))
        else $error("graded item shown without a table update");

    a_gap_then_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GAP) |=> (r_state == ST_UPD))
        else $error("gap stage not followed by update");

    a_graded_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_graded) |=> !(o_valid && o_graded))
        else $error("graded items closer than the table turnaround");

    a_seen_after_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |=> r_seen[$past(r_idx)])
        else $error("pixel not marked seen after its update");

endmodule

`default_nettype wire

// ===== sv/pixel_pulse_spacing_grader.sv =====
// Top level of the pulse-spacing grader: configuration registers, front end, queue, engine.
`default_nettype none

// Grades detector events by the spacing of pulses on each pixel. An item is
// taken at a clock edge with i_start high and o_busy low, and lands in a
// two-entry queue; o_busy is high only while that queue is full. The engine
// behind it takes an ungraded item (off-pixel, pixels 2 and 3, or beyond
// PIXEL_COUNT) straight to its result registers, and a graded item through
// a registered read of the pixel's table entry, the time-stamp subtract
// with the gap saturated to 32 bits, and a step that grades, corrects the
// counters and writes the entry back. Because of this read-modify-write
// loop no new item is taken while a graded one is in work. Each result
// shows on the o_ ports for exactly one cycle with o_valid high; the
// receiver cannot stall it, so results must be taken as they come. A
// pixel's table entry reads as its reset value until its first event,
// tracked by one valid flag per pixel, so no clearing pass runs after
// reset. Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take
// effect at the edge; indexes beyond the four registers are ignored.
// Write them only while no item is in flight.

module pixel_pulse_spacing_grader #(
    parameter int PIXEL_COUNT = 32,
    parameter int TIME_BITS   = 48,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire logic [pps_pkg::PIXEL_W-1:0]         i_pixel_number,
    input  wire logic                                i_on_pixel,
    input  wire logic [pps_pkg::ARRIVAL_W-1:0]       i_arrival_ticks,
    input  wire logic                                i_cfg_we,
    input  wire logic [pps_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [pps_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                                     o_valid,
    output logic                                     o_graded,
    output logic [pps_pkg::GRADE_W-1:0]              o_prior_final_grade,
    output logic [pps_pkg::GRADE_W-1:0]              o_tentative_grade,
    output logic [pps_pkg::OUT_COUNT_W-1:0]          o_total_events,
    output logic [pps_pkg::OUT_COUNT_W-1:0]          o_hires_events,
    output logic [pps_pkg::OUT_COUNT_W-1:0]          o_hires_midprimary_events,
    output logic [pps_pkg::OUT_COUNT_W-1:0]          o_mid_secondary_events,
    output logic [pps_pkg::OUT_COUNT_W-1:0]          o_low_events
);

    localparam int IW = $clog2(PIXEL_COUNT);
    localparam int QW = 1 + IW + TIME_BITS;   // queue item: graded flag, pixel, time

    pps_pkg::t_cfg         r_cfg;

    logic                  push;
    logic                  front_graded;
    logic [IW-1:0]         front_idx;
    logic [TIME_BITS-1:0]  front_time;
    logic [QW-1:0]         q_out;
    logic                  q_not_empty;
    logic                  q_full;
    logic                  pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_mid_gap      <= pps_pkg::RST_LOW_MID;
            r_cfg.mid_hi_gap       <= pps_pkg::RST_MID_HI;
            r_cfg.secondary_gap    <= pps_pkg::RST_SECONDARY;
            r_cfg.assumed_next_gap <= pps_pkg::RST_ASSUMED;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pps_pkg::CFG_LOW_MID:   r_cfg.low_mid_gap      <= i_cfg_data;
                pps_pkg::CFG_MID_HI:    r_cfg.mid_hi_gap       <= i_cfg_data;
                pps_pkg::CFG_SECONDARY: r_cfg.secondary_gap    <= i_cfg_data;
                pps_pkg::CFG_ASSUMED:   r_cfg.assumed_next_gap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // back-pressure only from a full queue
    assign o_busy = q_full;

    pps_front #(
        .PIXEL_COUNT (PIXEL_COUNT),
        .TIME_BITS   (TIME_BITS)
    ) u_front (
        .i_start         (i_start),
        .i_busy          (q_full),
        .i_pixel_number  (i_pixel_number),
        .i_on_pixel      (i_on_pixel),
        .i_arrival_ticks (i_arrival_ticks),
        .o_push          (push),
        .o_graded        (front_graded),
        .o_idx           (front_idx),
        .o_time          (front_time)
    );

    pps_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      ({front_graded, front_idx, front_time}),
        .i_pop       (pop),
        .o_data      (q_out),
        .o_not_empty (q_not_empty),
        .o_full      (q_full)
    );

    pps_back #(
        .PIXEL_COUNT (PIXEL_COUNT),
        .TIME_BITS   (TIME_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_cfg                     (r_cfg),
        .i_q_valid                 (q_not_empty),
        .i_q_graded                (q_out[QW-1]),
        .i_q_idx                   (q_out[QW-2 -: IW]),
        .i_q_time                  (q_out[TIME_BITS-1:0]),
        .o_pop                     (pop),
        .o_valid                   (o_valid),
        .o_graded                  (o_graded),
        .o_prior_final_grade       (o_prior_final_grade),
        .o_tentative_grade         (o_tentative_grade),
        .o_total_events            (o_total_events),
        .o_hires_events            (o_hires_events),
        .o_hires_midprimary_events (o_hires_midprimary_events),
        .o_mid_secondary_events    (o_mid_secondary_events),
        .o_low_events              (o_low_events)
    );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for pixel_pulse_spacing_grader: directed table, then randomised phases.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Register slots on the write port; indexes past CFG_ASSUMED exist but are ignored.
    localparam int CFG_SLOTS       = 8;
    localparam int NPIX            = 32;
    localparam int RANDOM_PHASES   = 7;
    localparam int GRADED_PER_PHASE = 82;
    // Cycles allowed after the last result before a register write or the end:
    // covers the queue of two and the engine's table steps, with margin.
    localparam int SETTLE_CYCLES   = 12;

    // One result item, laid out as the block reports it.
    typedef struct packed {
        logic                            graded;
        logic [pps_pkg::GRADE_W-1:0]     prior;
        logic [pps_pkg::GRADE_W-1:0]     tent;
        logic [pps_pkg::OUT_COUNT_W-1:0] total;
        logic [pps_pkg::OUT_COUNT_W-1:0] hires;
        logic [pps_pkg::OUT_COUNT_W-1:0] hires_mp;
        logic [pps_pkg::OUT_COUNT_W-1:0] mid_sec;
        logic [pps_pkg::OUT_COUNT_W-1:0] low;
    } t_grading;

    // Row of the directed table; 'fixed' rows carry a hand-written expectation.
    typedef struct {
        logic [pps_pkg::PIXEL_W-1:0]   pixel;
        logic                          on;
        logic [pps_pkg::ARRIVAL_W-1:0] ticks;
        bit                            fixed;
        t_grading                      want;
    } t_dir_row;

    // Ungraded item: everything reads zero.
    localparam t_grading NO_GRADE  = '0;
    // First hit on a pixel under reset settings: stored gap 12288, new gap saturated,
    // so both grades are H and the item lands in hires and hires_midprimary.
    localparam t_grading FIRST_HIT = '{1'b1, pps_pkg::GR_H, pps_pkg::GR_H,
                                       32'd1, 32'd1, 32'd1, 32'd0, 32'd0};

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_start = 1'b0;
    logic [pps_pkg::PIXEL_W-1:0]     i_pixel_number = '0;
    logic                            i_on_pixel = 1'b0;
    logic [pps_pkg::ARRIVAL_W-1:0]   i_arrival_ticks = '0;
    logic                            i_cfg_we = 1'b0;
    logic [pps_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [pps_pkg::CFG_W-1:0]       i_cfg_data = '0;
    logic                            o_busy;
    logic                            o_valid;
    logic                            o_graded;
    logic [pps_pkg::GRADE_W-1:0]     o_prior_final_grade;
    logic [pps_pkg::GRADE_W-1:0]     o_tentative_grade;
    logic [pps_pkg::OUT_COUNT_W-1:0] o_total_events;
    logic [pps_pkg::OUT_COUNT_W-1:0] o_hires_events;
    logic [pps_pkg::OUT_COUNT_W-1:0] o_hires_midprimary_events;
    logic [pps_pkg::OUT_COUNT_W-1:0] o_mid_secondary_events;
    logic [pps_pkg::OUT_COUNT_W-1:0] o_low_events;

    pixel_pulse_spacing_grader dut (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_start                   (i_start),
        .o_busy                    (o_busy),
        .i_pixel_number            (i_pixel_number),
        .i_on_pixel                (i_on_pixel),
        .i_arrival_ticks           (i_arrival_ticks),
        .i_cfg_we                  (i_cfg_we),
        .i_cfg_index               (i_cfg_index),
        .i_cfg_data                (i_cfg_data),
        .o_valid                   (o_valid),
        .o_graded                  (o_graded),
        .o_prior_final_grade       (o_prior_final_grade),
        .o_tentative_grade         (o_tentative_grade),
        .o_total_events            (o_total_events),
        .o_hires_events            (o_hires_events),
        .o_hires_midprimary_events (o_hires_midprimary_events),
        .o_mid_secondary_events    (o_mid_secondary_events),
        .o_low_events              (o_low_events)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor state: our own copy of the registers and pixel tables
    // ---------------------------------------------------------------
    pps_pkg::t_cfg                   cfg_shadow;
    logic [pps_pkg::ARRIVAL_W-1:0]   last_tick_tbl [NPIX];
    logic [pps_pkg::GAP_W-1:0]       prev_gap_tbl  [NPIX];
    pps_pkg::t_grade                 held_tbl      [NPIX];
    bit                              seen_tbl      [NPIX];
    logic [pps_pkg::OUT_COUNT_W-1:0] n_total       [NPIX];
    logic [pps_pkg::OUT_COUNT_W-1:0] n_hires       [NPIX];
    logic [pps_pkg::OUT_COUNT_W-1:0] n_hires_mp    [NPIX];
    logic [pps_pkg::OUT_COUNT_W-1:0] n_mid_sec     [NPIX];
    logic [pps_pkg::OUT_COUNT_W-1:0] n_low         [NPIX];

    t_grading               pending_grades [$];
    t_dir_row               directed_rows  [$];

    // Stimulus side: last arrival sent per pixel, so gaps can be steered.
    logic [pps_pkg::ARRIVAL_W-1:0]   sent_tick [NPIX];
    logic [pps_pkg::PIXEL_W-1:0]     hot_pix   [4] = '{5'd0, 5'd1, 5'd6, 5'd31};

    int mismatches      = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int burst_left      = 0;

    // Grade from the gap before an event and the gap after it.
    function automatic pps_pkg::t_grade spacing_grade(
            input logic [pps_pkg::GAP_W-1:0] gap_pre,
            input logic [pps_pkg::GAP_W-1:0] gap_post);
        logic is_low;
        logic is_mid;
        logic is_sec;
        is_low = (gap_pre < cfg_shadow.low_mid_gap) || (gap_post < cfg_shadow.low_mid_gap);
        is_mid = (gap_pre < cfg_shadow.mid_hi_gap) || (gap_post < cfg_shadow.mid_hi_gap);
        is_sec = gap_pre < cfg_shadow.secondary_gap;
        if (is_low) begin
            return is_sec ? pps_pkg::GR_LS : pps_pkg::GR_L;
        end else if (is_mid) begin
            return is_sec ? pps_pkg::GR_MS : pps_pkg::GR_M;
        end
        return is_sec ? pps_pkg::GR_S : pps_pkg::GR_H;
    endfunction

    // Add (+1) or take back (all ones) one item of grade g in pixel p's counters.
    function automatic void bump_class(input int p, input pps_pkg::t_grade g,
                                       input logic [pps_pkg::OUT_COUNT_W-1:0] delta);
        case (g)
            pps_pkg::GR_H: begin
                n_hires[p]    = n_hires[p] + delta;
                n_hires_mp[p] = n_hires_mp[p] + delta;
            end
            pps_pkg::GR_M:  n_hires_mp[p] = n_hires_mp[p] + delta;
            pps_pkg::GR_MS: n_mid_sec[p]  = n_mid_sec[p] + delta;
            default:        n_low[p]      = n_low[p] + delta;
        endcase
    endfunction

    // Work out the result of one accepted item and advance the pixel tables.
    function automatic t_grading grade_event(input logic [pps_pkg::PIXEL_W-1:0] pix,
                                             input logic on,
                                             input logic [pps_pkg::ARRIVAL_W-1:0] t);
        t_grading                      r;
        logic [pps_pkg::GAP_W-1:0]     gap;
        logic [pps_pkg::ARRIVAL_W-1:0] d;
        pps_pkg::t_grade               prior;
        pps_pkg::t_grade               tent;
        int                            p;
        r = '0;
        p = int'(pix);
        if (!on || pix == pps_pkg::PIX_SKIP_A || pix == pps_pkg::PIX_SKIP_B) begin
            return r;
        end
        if (!seen_tbl[p]) begin
            gap = pps_pkg::GAP_MAX;
        end else if (t < last_tick_tbl[p]) begin
            gap = '0;
        end else begin
            d   = t - last_tick_tbl[p];
            gap = (d > {16'd0, pps_pkg::GAP_MAX}) ? pps_pkg::GAP_MAX : d[pps_pkg::GAP_W-1:0];
        end
        prior = spacing_grade(prev_gap_tbl[p], gap);
        if (seen_tbl[p]) begin
            // the previous item was counted as tentative; swap it for its final class
            bump_class(p, held_tbl[p], '1);
            bump_class(p, prior, 32'd1);
        end
        tent             = spacing_grade(gap, cfg_shadow.assumed_next_gap);
        prev_gap_tbl[p]  = gap;
        last_tick_tbl[p] = t;
        held_tbl[p]      = tent;
        seen_tbl[p]      = 1'b1;
        bump_class(p, tent, 32'd1);
        n_total[p]       = n_total[p] + 32'd1;
        r.graded   = 1'b1;
        r.prior    = prior;
        r.tent     = tent;
        r.total    = n_total[p];
        r.hires    = n_hires[p];
        r.hires_mp = n_hires_mp[p];
        r.mid_sec  = n_mid_sec[p];
        r.low      = n_low[p];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Sender idle time after each item, with occasional back-to-back bursts.
    function automatic int draw_idle();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(5, 20);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // ---------------------------------------------------------------
    // Driving: inputs change on the falling edge, acceptance is seen
    // at the rising edge with start high and busy low.
    // ---------------------------------------------------------------
    task automatic send_item(input logic [pps_pkg::PIXEL_W-1:0] pix, input logic on,
                             input logic [pps_pkg::ARRIVAL_W-1:0] ticks, input bit fixed,
                             input t_grading want);
        t_grading pred;
        int       idle;
        @(negedge i_clk);
        i_start         <= 1'b1;
        i_pixel_number  <= pix;
        i_on_pixel      <= on;
        i_arrival_ticks <= ticks;
        do @(posedge i_clk); while (o_busy);
        // predictor always runs so its tables stay in step with typed-in rows
        pred = grade_event(pix, on, ticks);
        pending_grades.push_back(fixed ? want : pred);
        items_sent++;
        sent_tick[pix] = ticks;
        // with no gap, start stays high and the next call just swaps the item
        idle = draw_idle();
        if (idle > 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (idle - 1) @(negedge i_clk);
        end
    endtask

    // Drop start, let every outstanding item come back, then let the engine settle.
    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_grades.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [pps_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [pps_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            pps_pkg::CFG_LOW_MID:   cfg_shadow.low_mid_gap      = data;
            pps_pkg::CFG_MID_HI:    cfg_shadow.mid_hi_gap       = data;
            pps_pkg::CFG_SECONDARY: cfg_shadow.secondary_gap    = data;
            pps_pkg::CFG_ASSUMED:   cfg_shadow.assumed_next_gap = data;
            default: ;  // spare slot, the block ignores it
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_row(input logic [pps_pkg::PIXEL_W-1:0] pix, input logic on,
                           input logic [pps_pkg::ARRIVAL_W-1:0] ticks, input bit fixed,
                           input t_grading want);
        t_dir_row row;
        row.pixel = pix;
        row.on    = on;
        row.ticks = ticks;
        row.fixed = fixed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // ---------------------------------------------------------------
    // Result checking: every strobe is matched against the oldest item.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_grading want;
        if (i_rst_n && o_valid) begin
            if (pending_grades.size() == 0) begin
                $error("result strobe with no item outstanding");
                mismatches++;
            end else begin
                want = pending_grades.pop_front();
                check_field("graded", 32'(want.graded), 32'(o_graded));
                check_field("prior_final_grade", 32'(want.prior), 32'(o_prior_final_grade));
                check_field("tentative_grade", 32'(want.tent), 32'(o_tentative_grade));
                check_field("total_events", want.total, o_total_events);
                check_field("hires_events", want.hires, o_hires_events);
                check_field("hires_midprimary_events", want.hires_mp,
                            o_hires_midprimary_events);
                check_field("mid_secondary_events", want.mid_sec, o_mid_secondary_events);
                check_field("low_events", want.low, o_low_events);
                results_checked++;
            end
        end
    end

    // Watchdog: far beyond the slowest legal run of about 650 items.
    initial begin
        #2_000_000;
        $display("pixel_pulse_spacing_grader: mismatch");
        $finish;
    end

    initial begin
        logic [pps_pkg::PIXEL_W-1:0]   pix;
        logic                          on;
        logic [pps_pkg::ARRIVAL_W-1:0] ticks;
        logic [pps_pkg::ARRIVAL_W-1:0] step;
        logic [pps_pkg::CFG_W-1:0]     edge_reg;
        int                            graded_cnt;

        // predictor starts from the reset state of the block
        cfg_shadow = '{pps_pkg::RST_LOW_MID, pps_pkg::RST_MID_HI, pps_pkg::RST_SECONDARY,
                       pps_pkg::RST_ASSUMED};
        for (int p = 0; p < NPIX; p++) begin
            last_tick_tbl[p] = '0;
            prev_gap_tbl[p]  = pps_pkg::INITIAL_GAP;
            held_tbl[p]      = pps_pkg::GR_H;
            seen_tbl[p]      = 1'b0;
            n_total[p]       = '0;
            n_hires[p]       = '0;
            n_hires_mp[p]    = '0;
            n_mid_sec[p]     = '0;
            n_low[p]         = '0;
            sent_tick[p]     = '0;
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, reset settings. Ungraded and first-hit rows are typed in.
        add_row(5'd0,  1'b0, 48'd0,               1, NO_GRADE);   // off-pixel
        add_row(5'd2,  1'b1, 48'hFFFF_FFFF_FFFF,  1, NO_GRADE);   // skipped pixel, top time
        add_row(5'd3,  1'b1, 48'd0,               1, NO_GRADE);   // other skipped pixel
        add_row(5'd31, 1'b1, 48'hFFFF_FFFF_FFFF,  1, FIRST_HIT);  // top pixel, first hit
        add_row(5'd0,  1'b1, 48'd0,               1, FIRST_HIT);
        add_row(5'd0,  1'b1, 48'd100,             0, NO_GRADE);   // low-resolution gap
        add_row(5'd0,  1'b1, 48'd1000,            0, NO_GRADE);   // mid secondary
        add_row(5'd0,  1'b1, 48'd5000,            0, NO_GRADE);   // high
        add_row(5'd0,  1'b1, 48'd50,              0, NO_GRADE);   // time runs backward
        add_row(5'd1,  1'b1, 48'd0,               1, FIRST_HIT);
        add_row(5'd1,  1'b1, 48'h2_0000_0000,     0, NO_GRADE);   // gap saturates
        add_row(5'd31, 1'b1, 48'd0,               0, NO_GRADE);   // backward from top time
        add_row(5'd4,  1'b1, 48'h5555_5555_5555,  1, FIRST_HIT);
        add_row(5'd4,  1'b1, 48'h5555_5555_5732,  0, NO_GRADE);   // gap 477, mid
        add_row(5'd4,  1'b1, 48'h5555_5555_5910,  0, NO_GRADE);   // gap 478
        add_row(5'd4,  1'b1, 48'h5555_5555_58F2,  0, NO_GRADE);   // backward by 30
        add_row(5'd4,  1'b1, 48'h5555_5555_5AB0,  0, NO_GRADE);   // gap 446, on the edge
        add_row(5'd4,  1'b1, 48'h5555_5555_618D,  0, NO_GRADE);   // gap 1757, on the edge
        add_row(5'd5,  1'b0, 48'hAAAA_AAAA_AAAA,  1, NO_GRADE);   // off-pixel, odd bits
        add_row(5'd30, 1'b1, 48'hAAAA_AAAA_AAAA,  1, FIRST_HIT);
        add_row(5'd30, 1'b1, 48'hAAAA_AAAA_DAAA,  0, NO_GRADE);   // gap 12288
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].pixel, directed_rows[i].on, directed_rows[i].ticks,
                      directed_rows[i].fixed, directed_rows[i].want);
        end
        drain();

        // Random phases: each one rewrites every register, spare slots included.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            for (int k = pps_pkg::CFG_ASSUMED + 1; k < CFG_SLOTS; k++) begin
                write_reg(k[pps_pkg::CFG_INDEX_W-1:0], $urandom);
            end
            case (ph)
                0: begin  // all zero: nothing is below a threshold
                    write_reg(pps_pkg::CFG_LOW_MID, '0);
                    write_reg(pps_pkg::CFG_MID_HI, '0);
                    write_reg(pps_pkg::CFG_SECONDARY, '0);
                    write_reg(pps_pkg::CFG_ASSUMED, '0);
                end
                1: begin  // all ones: nearly everything is low secondary
                    write_reg(pps_pkg::CFG_LOW_MID, '1);
                    write_reg(pps_pkg::CFG_MID_HI, '1);
                    write_reg(pps_pkg::CFG_SECONDARY, '1);
                    write_reg(pps_pkg::CFG_ASSUMED, '1);
                end
                2: begin
                    write_reg(pps_pkg::CFG_LOW_MID, pps_pkg::RST_LOW_MID);
                    write_reg(pps_pkg::CFG_MID_HI, pps_pkg::RST_MID_HI);
                    write_reg(pps_pkg::CFG_SECONDARY, pps_pkg::RST_SECONDARY);
                    write_reg(pps_pkg::CFG_ASSUMED, pps_pkg::RST_ASSUMED);
                end
                default: begin  // thresholds in the range the gaps below reach
                    write_reg(pps_pkg::CFG_LOW_MID, $urandom_range(0, 2000));
                    write_reg(pps_pkg::CFG_MID_HI, $urandom_range(0, 4000));
                    write_reg(pps_pkg::CFG_SECONDARY, $urandom_range(0, 4000));
                    write_reg(pps_pkg::CFG_ASSUMED, $urandom_range(0, 20000));
                end
            endcase

            graded_cnt = 0;
            while (graded_cnt < GRADED_PER_PHASE) begin
                // mostly a few busy pixels so each builds a long history
                if ($urandom_range(0, 3) != 0) begin
                    pix = hot_pix[2'($urandom_range(0, 3))];
                end else begin
                    pix = pps_pkg::PIXEL_W'($urandom_range(0, NPIX - 1));
                end
                on = ($urandom_range(0, 11) != 0);
                case ($urandom_range(0, 9))
                    0, 1: step = pps_pkg::ARRIVAL_W'($urandom_range(0, 600));
                    2, 3: step = pps_pkg::ARRIVAL_W'($urandom_range(300, 2500));
                    4, 5: step = pps_pkg::ARRIVAL_W'($urandom_range(1500, 20000));
                    6: begin  // land on or beside one of the current thresholds
                        case ($urandom_range(0, 3))
                            0: edge_reg = cfg_shadow.low_mid_gap;
                            1: edge_reg = cfg_shadow.mid_hi_gap;
                            2: edge_reg = cfg_shadow.secondary_gap;
                            default: edge_reg = cfg_shadow.assumed_next_gap;
                        endcase
                        step = {16'd0, edge_reg} + pps_pkg::ARRIVAL_W'($urandom_range(0, 2))
                             - 48'd1;
                    end
                    7: step = {14'd0, 2'($urandom_range(0, 3)), 32'($urandom)};
                    default: step = '0;
                endcase
                ticks = sent_tick[pix] + step;
                if (step == '0) begin
                    // half of these run time backward, the rest are any time at all
                    if ($urandom_range(0, 1) == 0) begin
                        ticks = sent_tick[pix] - pps_pkg::ARRIVAL_W'($urandom_range(1, 5000));
                    end else begin
                        ticks = {16'($urandom), 32'($urandom)};
                    end
                end
                if (on && pix != pps_pkg::PIX_SKIP_A && pix != pps_pkg::PIX_SKIP_B) begin
                    graded_cnt++;
                end
                send_item(pix, on, ticks, 0, NO_GRADE);
            end
            drain();
        end

        $display("%0d items sent over a directed table and %0d register phases,",
                 items_sent, RANDOM_PHASES);
        $display("%0d results checked field by field, %0d register writes", results_checked,
                 cfg_writes);
        if (mismatches == 0 && pending_grades.size() == 0) begin
            $display("pixel_pulse_spacing_grader: match");
        end else begin
            $display("pixel_pulse_spacing_grader: mismatch");
        end
        $finish;
    end

endmodule
